// ===== hdl/srlb_pkg.sv =====
`timescale 1ns / 1ps
package srlb_pkg;

   // table sizes
   localparam int BLOCK_ENTRIES_DEF = 64;
   localparam int RATE_ENTRIES_DEF  = 64;

   // seconds from ns: ((ns >> 9) * SEC_RECIP) >> SEC_SHIFT, with 1e9 = 2^9 * 1953125
   // SEC_RECIP = ceil(2^76 / 1953125), exact for every 64-bit timestamp
   localparam logic [55:0] SEC_RECIP = 56'd38685626227668134;
   localparam int SEC_SHIFT = 76;

   // register indexes
   localparam logic [2:0] CSR_WINDOW_NS   = 3'd0;
   localparam logic [2:0] CSR_MAX_PACKETS = 3'd1;
   localparam logic [2:0] CSR_MAX_BYTES   = 3'd2;
   localparam logic [2:0] CSR_ESCALATE    = 3'd3;
   localparam logic [2:0] CSR_IPV6_ENABLE = 3'd4;

   // register reset values
   localparam logic [39:0] WINDOW_NS_RST   = 40'd1000000000;
   localparam logic [23:0] MAX_PACKETS_RST = 24'd1000;
   localparam logic [31:0] MAX_BYTES_RST   = 32'd10485760;
   localparam logic [7:0]  ESCALATE_RST    = 8'd5;

   // result reasons
   localparam logic [2:0] REASON_PASS  = 3'd0;
   localparam logic [2:0] REASON_BLOCK = 3'd1;
   localparam logic [2:0] REASON_RATE  = 3'd2;
   localparam logic [2:0] REASON_ESC   = 3'd3;
   localparam logic [2:0] REASON_HOST  = 3'd4;

   // blocklist flags
   localparam logic [2:0] FLAG_NONE = 3'd0;
   localparam logic [2:0] FLAG_RATE = 3'd4;
   localparam logic [2:0] FLAG_MAX  = 3'd5;

   typedef struct packed {
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
   } key_type;

   typedef struct packed {
      logic [2:0]  flag;
      logic [63:0] pkt;
      logic [63:0] bytes;
      logic [34:0] last_s;
   } block_data_type;

   typedef struct packed {
      logic [63:0] start;
      logic [31:0] pkt;
      logic [31:0] bytes;
   } rate_data_type;

   localparam int BLOCK_DW = $bits(block_data_type);
   localparam int RATE_DW  = $bits(rate_data_type);

endpackage

// ===== hdl/source_rate_limiter_blocklist_core.sv =====
`timescale 1ns / 1ps
// an accepted item passes the 4-step seconds multiplier, then the match, read and
// decision stages before its result is registered; a stalled result holds the decision stage
// a new item is taken only once the result is registered
// both tables are rows of cells compared in parallel against the item key
// reset (synchronous, active high) clears all entry valid bits and fill counts, sets each
// lru rank to its cell index at once and loads the register defaults; no clearing pass
module source_rate_limiter_blocklist_core #(
   parameter int BLOCK_ENTRIES = srlb_pkg::BLOCK_ENTRIES_DEF,
   parameter int RATE_ENTRIES  = srlb_pkg::RATE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_is_v6,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [15:0] req_pkt_len,
   input  logic [63:0] req_timestamp_ns,
   input  logic [2:0]  req_set_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_drop,
   output logic [2:0]  rsp_reason,
   output logic [2:0]  rsp_hit_flag,
   output logic [31:0] rsp_window_packets,
   output logic [31:0] rsp_window_bytes,
   output logic [63:0] rsp_blocked_packets,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [39:0] csr_data
);
   import srlb_pkg::*;

   localparam int BAW = $clog2(BLOCK_ENTRIES);
   localparam int RAW = $clog2(RATE_ENTRIES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_MATCH = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CALC  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [39:0] window_ff;
   logic [23:0] maxp_ff;
   logic [31:0] maxb_ff;
   logic [7:0]  esc_ff;
   logic        v6en_ff;
   logic [31:0] esc_lim_ff;

   key_type     key_ff;
   logic        host_ff;
   logic [15:0] len_ff;
   logic [63:0] now_ff;
   logic [2:0]  flag_ff;
   logic [34:0] now_s_ff;

   logic [BLOCK_ENTRIES-1:0] bmatch, bvict, bm_ff, bv_ff, bsel;
   logic [RATE_ENTRIES-1:0]  rmatch, rvict, rm_ff, rv_ff, rsel;
   logic [BLOCK_DW-1:0]      brd_raw;
   logic [RATE_DW-1:0]       rrd_raw;
   logic [BAW-1:0]           bage_raw, bage_ff;
   logic [RAW-1:0]           rage_raw, rage_ff;
   block_data_type           brd_ff, bwd;
   rate_data_type            rrd_ff, rwd;
   logic                     bhit_ff, rhit_ff;

   logic        accept, go, div_done;
   logic [34:0] div_q;
   logic        bw, bt, rw, rt;
   logic        o_drop;
   logic [2:0]  o_reason, o_hit;
   logic [31:0] o_wp, o_wb;
   logic [63:0] o_bp;
   logic [63:0] bpkt1, diff;
   logic [64:0] bbyte_s;
   logic [31:0] rpkt1, rbyte1;
   logic [32:0] rbyte_s;
   logic        expired;

   logic        rsp_valid_ff;
   logic        drop_ff;
   logic [2:0]  reason_ff, hit_ff;
   logic [31:0] wp_ff, wb_ff;
   logic [63:0] bp_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign go        = (state_ff == S_CALC) && (!rsp_valid_ff || !rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_NS_RST;
         maxp_ff   <= MAX_PACKETS_RST;
         maxb_ff   <= MAX_BYTES_RST;
         esc_ff    <= ESCALATE_RST;
         v6en_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_NS:   window_ff <= csr_data;
            CSR_MAX_PACKETS: maxp_ff   <= csr_data[23:0];
            CSR_MAX_BYTES:   maxb_ff   <= csr_data[31:0];
            CSR_ESCALATE:    esc_ff    <= csr_data[7:0];
            CSR_IPV6_ENABLE: v6en_ff   <= csr_data[0];
            default: ;
         endcase
      end
      esc_lim_ff <= {24'b0, esc_ff} * {8'b0, maxp_ff};
   end

   // seconds from the timestamp
   srlb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .dividend(req_timestamp_ns),
      .done    (div_done),
      .quotient(div_q)
   );

   assign bsel = (|bm_ff) ? bm_ff : bv_ff;
   assign rsel = (|rm_ff) ? rm_ff : rv_ff;

   srlb_table #(.ENTRIES(BLOCK_ENTRIES), .DW(BLOCK_DW)) u_block (
      .clock   (clock),
      .reset   (reset),
      .key_in  (key_ff),
      .sel     (bsel),
      .wr_en   (go && bw),
      .wr_data (bwd),
      .touch_en(go && bt),
      .mine    (bage_ff),
      .match   (bmatch),
      .victim  (bvict),
      .rd_data (brd_raw),
      .rd_age  (bage_raw)
   );

   srlb_table #(.ENTRIES(RATE_ENTRIES), .DW(RATE_DW)) u_rate (
      .clock   (clock),
      .reset   (reset),
      .key_in  (key_ff),
      .sel     (rsel),
      .wr_en   (go && rw),
      .wr_data (rwd),
      .touch_en(go && rt),
      .mine    (rage_ff),
      .match   (rmatch),
      .victim  (rvict),
      .rd_data (rrd_raw),
      .rd_age  (rage_raw)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_MATCH;
         S_MATCH: state_in = S_READ;
         S_READ:  state_in = S_CALC;
         S_CALC:  if (go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // item capture, lookup and read stages
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         key_ff.v6 <= req_is_v6;
         key_ff.hi <= req_is_v6 ? req_addr_hi : 64'b0;
         key_ff.lo <= req_is_v6 ? req_addr_lo : {32'b0, req_addr_lo[31:0]};
         host_ff   <= req_mode;
         len_ff    <= req_pkt_len;
         now_ff    <= req_timestamp_ns;
         flag_ff   <= req_set_flag;
      end
      if (div_done) begin
         now_s_ff <= div_q;
      end
      if (state_ff == S_MATCH) begin
         bm_ff <= bmatch;
         bv_ff <= bvict;
         rm_ff <= rmatch;
         rv_ff <= rvict;
      end
      if (state_ff == S_READ) begin
         bhit_ff <= |bm_ff;
         rhit_ff <= |rm_ff;
         brd_ff  <= brd_raw;
         rrd_ff  <= rrd_raw;
         bage_ff <= bage_raw;
         rage_ff <= rage_raw;
      end
   end

   // saturating counter updates and window expiry check
   always_comb begin
      bpkt1   = (&brd_ff.pkt) ? brd_ff.pkt : brd_ff.pkt + 64'd1;
      bbyte_s = {1'b0, brd_ff.bytes} + {49'b0, len_ff};
      rpkt1   = (&rrd_ff.pkt) ? rrd_ff.pkt : rrd_ff.pkt + 32'd1;
      rbyte_s = {1'b0, rrd_ff.bytes} + {17'b0, len_ff};
      rbyte1  = rbyte_s[32] ? 32'hFFFF_FFFF : rbyte_s[31:0];
      diff    = now_ff - rrd_ff.start;
      expired = diff > {24'b0, window_ff};
   end

   // decision and write-back
   always_comb begin
      bw       = 1'b0;
      bt       = 1'b0;
      rw       = 1'b0;
      rt       = 1'b0;
      bwd      = brd_ff;
      rwd      = rrd_ff;
      o_drop   = 1'b0;
      o_reason = REASON_PASS;
      o_hit    = FLAG_NONE;
      o_wp     = '0;
      o_wb     = '0;
      o_bp     = '0;
      if (host_ff) begin
         // host flag write
         o_reason = REASON_HOST;
         if (flag_ff <= FLAG_MAX && (bhit_ff || flag_ff != FLAG_NONE)) begin
            bw       = 1'b1;
            bt       = 1'b1;
            bwd.flag = flag_ff;
            if (!bhit_ff) begin
               bwd.pkt    = '0;
               bwd.bytes  = '0;
               bwd.last_s = now_s_ff;
            end
         end
         if (bhit_ff) begin
            o_hit = (flag_ff <= FLAG_MAX) ? flag_ff : brd_ff.flag;
            o_bp  = brd_ff.pkt;
         end else if (flag_ff <= FLAG_MAX) begin
            o_hit = flag_ff;
         end
      end else if (key_ff.v6 && !v6en_ff) begin
         // unchecked ipv6 item
      end else if (bhit_ff && brd_ff.flag != FLAG_NONE) begin
         // blocklisted source
         bw         = 1'b1;
         bt         = 1'b1;
         bwd.pkt    = bpkt1;
         bwd.bytes  = bbyte_s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : bbyte_s[63:0];
         bwd.last_s = now_s_ff;
         o_drop     = 1'b1;
         o_reason   = REASON_BLOCK;
         o_hit      = brd_ff.flag;
         o_bp       = bpkt1;
      end else begin
         // rate window path
         bt = bhit_ff;
         rw = 1'b1;
         rt = 1'b1;
         if (bhit_ff) begin
            o_bp = brd_ff.pkt;
         end
         if (!rhit_ff || expired) begin
            rwd.start = now_ff;
            rwd.pkt   = 32'd1;
            rwd.bytes = {16'b0, len_ff};
         end else begin
            rwd.pkt   = rpkt1;
            rwd.bytes = rbyte1;
            if (rpkt1 > {8'b0, maxp_ff} || rbyte1 > maxb_ff) begin
               o_drop   = 1'b1;
               o_reason = REASON_RATE;
               if (rpkt1 > esc_lim_ff) begin
                  bw         = 1'b1;
                  bt         = 1'b1;
                  bwd.flag   = FLAG_RATE;
                  bwd.pkt    = '0;
                  bwd.bytes  = '0;
                  bwd.last_s = now_s_ff;
                  o_reason   = REASON_ESC;
                  o_bp       = '0;
               end
            end
         end
         o_wp = rwd.pkt;
         o_wb = rwd.bytes;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go) begin
         drop_ff   <= o_drop;
         reason_ff <= o_reason;
         hit_ff    <= o_hit;
         wp_ff     <= o_wp;
         wb_ff     <= o_wb;
         bp_ff     <= o_bp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drop            = drop_ff;
   assign rsp_reason          = reason_ff;
   assign rsp_hit_flag        = hit_ff;
   assign rsp_window_packets  = wp_ff;
   assign rsp_window_bytes    = wb_ff;
   assign rsp_blocked_packets = bp_ff;

`ifndef SYNTHESIS
   a_accept_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DIV)
      else $error("accepted item did not start the divider");
   a_rsp_from_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_CALC)
      else $error("result raised outside the decision stage");
   a_drop_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drop_ff |-> reason_ff == REASON_BLOCK ||
         reason_ff == REASON_RATE || reason_ff == REASON_ESC)
      else $error("drop with a pass reason");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CALC && !go |=> state_ff == S_CALC)
      else $error("decision stage left without a result");
`endif

endmodule

// ===== hdl/srlb_div.sv =====
`timescale 1ns / 1ps
module srlb_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   output logic        done,
   output logic [34:0] quotient
);
   import srlb_pkg::*;

   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [1:0]   step_ff, step_in;
   logic [54:0]  dvd_ff, dvd_in;
   logic [110:0] acc_ff, acc_in;
   logic [27:0]  a_part, b_part;
   logic [55:0]  prod;
   logic [110:0] prod_sh;

   // reciprocal multiply in four steps, one 28x28 partial product per cycle
   always_comb begin
      a_part  = step_ff[1] ? {1'b0, dvd_ff[54:28]} : dvd_ff[27:0];
      b_part  = step_ff[0] ? SEC_RECIP[55:28] : SEC_RECIP[27:0];
      prod    = a_part * b_part;
      case (step_ff)
         2'd0:    prod_sh = {55'b0, prod};
         2'd3:    prod_sh = {prod[54:0], 56'b0};
         default: prod_sh = {27'b0, prod, 28'b0};
      endcase
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         dvd_in  = dividend[63:9];
         acc_in  = '0;
      end else if (run_ff) begin
         acc_in  = acc_ff + prod_sh;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      acc_ff <= acc_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff[SEC_SHIFT+34:SEC_SHIFT];

endmodule

// ===== hdl/srlb_cell.sv =====
`timescale 1ns / 1ps
module srlb_cell #(
   parameter int ENTRIES = 64,
   parameter int INDEX   = 0,
   parameter int DW      = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  srlb_pkg::key_type          key_in,
   input  logic                       sel,
   input  logic                       wr_en,
   input  logic [DW-1:0]              wr_data,
   input  logic                       touch_en,
   input  logic [$clog2(ENTRIES)-1:0] mine,
   output logic                       valid,
   output logic                       match,
   output logic [$clog2(ENTRIES)-1:0] age,
   output logic [DW-1:0]              data
);
   import srlb_pkg::*;

   localparam int AW = $clog2(ENTRIES);

   logic          valid_ff;
   key_type       key_ff;
   logic [DW-1:0] data_ff;
   logic [AW-1:0] age_ff, age_in;

   // lru rank update
   always_comb begin
      age_in = age_ff;
      if (touch_en) begin
         if (sel) begin
            age_in = '0;
         end else if (age_ff < mine) begin
            age_in = age_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= AW'(INDEX);
      end else begin
         age_ff <= age_in;
         if (wr_en && sel) begin
            valid_ff <= 1'b1;
         end
      end
      if (wr_en && sel) begin
         key_ff  <= key_in;
         data_ff <= wr_data;
      end
   end

   assign valid = valid_ff;
   assign match = valid_ff && (key_ff == key_in);
   assign age   = age_ff;
   assign data  = data_ff;

endmodule

// ===== hdl/srlb_table.sv =====
`timescale 1ns / 1ps
module srlb_table #(
   parameter int ENTRIES = 64,
   parameter int DW      = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  srlb_pkg::key_type          key_in,
   input  logic [ENTRIES-1:0]         sel,
   input  logic                       wr_en,
   input  logic [DW-1:0]              wr_data,
   input  logic                       touch_en,
   input  logic [$clog2(ENTRIES)-1:0] mine,
   output logic [ENTRIES-1:0]         match,
   output logic [ENTRIES-1:0]         victim,
   output logic [DW-1:0]              rd_data,
   output logic [$clog2(ENTRIES)-1:0] rd_age
);
   import srlb_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int FW = $clog2(ENTRIES + 1);

   logic [ENTRIES-1:0] valid;
   logic [AW-1:0]      age  [ENTRIES];
   logic [DW-1:0]      data [ENTRIES];
   logic [FW-1:0]      fill_ff;
   logic               full;

   // row of entry cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      srlb_cell #(.ENTRIES(ENTRIES), .INDEX(i), .DW(DW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .key_in  (key_in),
         .sel     (sel[i]),
         .wr_en   (wr_en),
         .wr_data (wr_data),
         .touch_en(touch_en),
         .mine    (mine),
         .valid   (valid[i]),
         .match   (match[i]),
         .age     (age[i]),
         .data    (data[i])
      );
   end

   // valid entries form a prefix, so the first free one is the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (wr_en && ((sel & valid) == '0) && !full) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   assign full = fill_ff == FW'(ENTRIES);

   // victim: first free entry, else the oldest
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = full ? (age[i] == AW'(ENTRIES - 1)) : (fill_ff == FW'(i));
      end
   end

   // one-hot read of the selected cell
   always_comb begin
      rd_data = '0;
      rd_age  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rd_data = rd_data | (sel[i] ? data[i] : '0);
         rd_age  = rd_age | (sel[i] ? age[i] : '0);
      end
   end

endmodule

// ===== sim/tb_source_rate_limiter_blocklist_core.sv =====
`timescale 1ns / 1ps
module tb_source_rate_limiter_blocklist_core;
   import srlb_pkg::*;

   localparam int NE = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 600;
   localparam int SETTLE = 90;

   typedef struct {
      logic        mode;
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [15:0] len;
      logic [63:0] ts;
      logic [2:0]  flag;
   } pkt_item_type;

   typedef struct {
      logic        drop;
      logic [2:0]  reason;
      logic [2:0]  hit_flag;
      logic [31:0] wpkts;
      logic [31:0] wbytes;
      logic [63:0] bpkts;
   } verdict_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_mode = 0;
   logic        req_is_v6 = 0;
   logic [63:0] req_addr_hi = 0;
   logic [63:0] req_addr_lo = 0;
   logic [15:0] req_pkt_len = 0;
   logic [63:0] req_timestamp_ns = 0;
   logic [2:0]  req_set_flag = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_drop;
   logic [2:0]  rsp_reason;
   logic [2:0]  rsp_hit_flag;
   logic [31:0] rsp_window_packets;
   logic [31:0] rsp_window_bytes;
   logic [63:0] rsp_blocked_packets;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_index = 0;
   logic [39:0] csr_data = 0;

   source_rate_limiter_blocklist_core i_dut (.*);

   always #2 clock = ~clock;

   // shadow configuration
   logic [39:0] cfg_window;
   logic [23:0] cfg_max_pkts;
   logic [31:0] cfg_max_bytes;
   logic [7:0]  cfg_escalate;
   logic        cfg_v6_en;

   // shadow blocklist
   bit          bl_valid [NE];
   logic [63:0] bl_hi [NE];
   logic [63:0] bl_lo [NE];
   bit          bl_v6 [NE];
   logic [2:0]  bl_flag [NE];
   logic [63:0] bl_pkts [NE];
   int          bl_age [NE];

   // shadow rate table
   bit          rt_valid [NE];
   logic [63:0] rt_hi [NE];
   logic [63:0] rt_lo [NE];
   bit          rt_v6 [NE];
   logic [63:0] rt_start [NE];
   logic [31:0] rt_pkts [NE];
   logic [31:0] rt_bytes [NE];
   int          rt_age [NE];

   pkt_item_type pending_items[$];
   verdict_type  expected_verdicts[$];
   pkt_item_type offered;

   bit quiet = 0;
   bit hold_request = 0;
   int hold_cnt = 0;
   int errors = 0;
   int idle_cycles = 0;
   bit done = 0;

   logic [63:0] now_ts;
   logic [63:0] pool_hi [80];
   logic [63:0] pool_lo [80];
   bit          pool_v6 [80];

   function automatic int block_find(bit v6, logic [63:0] hi, logic [63:0] lo);
      for (int j = 0; j < NE; j++)
         if (bl_valid[j] && bl_v6[j] == v6 && bl_hi[j] == hi && bl_lo[j] == lo) return j;
      return -1;
   endfunction

   function automatic int rate_find(bit v6, logic [63:0] hi, logic [63:0] lo);
      for (int j = 0; j < NE; j++)
         if (rt_valid[j] && rt_v6[j] == v6 && rt_hi[j] == hi && rt_lo[j] == lo) return j;
      return -1;
   endfunction

   // lru: age 0 is most recent
   function automatic void block_touch(int idx);
      int mine;
      mine = bl_age[idx];
      for (int j = 0; j < NE; j++) if (bl_age[j] < mine) bl_age[j]++;
      bl_age[idx] = 0;
   endfunction

   function automatic void rate_touch(int idx);
      int mine;
      mine = rt_age[idx];
      for (int j = 0; j < NE; j++) if (rt_age[j] < mine) rt_age[j]++;
      rt_age[idx] = 0;
   endfunction

   function automatic int block_alloc(bit v6, logic [63:0] hi, logic [63:0] lo);
      int best;
      best = -1;
      for (int j = 0; j < NE && best < 0; j++) if (!bl_valid[j]) best = j;
      if (best < 0) begin
         best = 0;
         for (int j = 1; j < NE; j++) if (bl_age[j] > bl_age[best]) best = j;
      end
      bl_valid[best] = 1;
      bl_v6[best] = v6;
      bl_hi[best] = hi;
      bl_lo[best] = lo;
      bl_pkts[best] = 0;
      return best;
   endfunction

   function automatic int rate_victim();
      int best;
      for (int j = 0; j < NE; j++) if (!rt_valid[j]) return j;
      best = 0;
      for (int j = 1; j < NE; j++) if (rt_age[j] > rt_age[best]) best = j;
      return best;
   endfunction

   function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // compute the verdict for one accepted item and update the shadow tables
   function automatic verdict_type limiter_verdict(pkt_item_type it);
      verdict_type v;
      logic [63:0] hi, lo;
      int          b, r;
      v = '{default: '0};
      hi = it.v6 ? it.hi : 64'd0;
      lo = it.v6 ? it.lo : {32'd0, it.lo[31:0]};
      b = block_find(it.v6, hi, lo);
      if (it.mode) begin
         v.reason = REASON_HOST;
         if (it.flag <= FLAG_MAX) begin
            if (b < 0 && it.flag != FLAG_NONE) b = block_alloc(it.v6, hi, lo);
            if (b >= 0) begin
               bl_flag[b] = it.flag;
               block_touch(b);
            end
         end
         if (b >= 0) begin
            v.hit_flag = bl_flag[b];
            v.bpkts = bl_pkts[b];
         end
      end else if (it.v6 && !cfg_v6_en) begin
         // unchecked pass
      end else if (b >= 0 && bl_flag[b] != FLAG_NONE) begin
         block_touch(b);
         if (bl_pkts[b] != '1) bl_pkts[b]++;
         v.drop = 1;
         v.reason = REASON_BLOCK;
         v.hit_flag = bl_flag[b];
         v.bpkts = bl_pkts[b];
      end else begin
         if (b >= 0) begin
            block_touch(b);
            v.bpkts = bl_pkts[b];
         end
         r = rate_find(it.v6, hi, lo);
         if (r < 0) begin
            r = rate_victim();
            rt_valid[r] = 1;
            rt_v6[r] = it.v6;
            rt_hi[r] = hi;
            rt_lo[r] = lo;
            rt_start[r] = it.ts;
            rt_pkts[r] = 1;
            rt_bytes[r] = {16'd0, it.len};
         end else if (it.ts - rt_start[r] > {24'd0, cfg_window}) begin
            rt_start[r] = it.ts;
            rt_pkts[r] = 1;
            rt_bytes[r] = {16'd0, it.len};
         end else begin
            rt_pkts[r] = sat32(rt_pkts[r], 1);
            rt_bytes[r] = sat32(rt_bytes[r], {16'd0, it.len});
            if (rt_pkts[r] > cfg_max_pkts || rt_bytes[r] > cfg_max_bytes) begin
               v.drop = 1;
               v.reason = REASON_RATE;
               if ({32'd0, rt_pkts[r]} > 64'(cfg_escalate) * 64'(cfg_max_pkts)) begin
                  if (b < 0) b = block_alloc(it.v6, hi, lo);
                  bl_flag[b] = FLAG_RATE;
                  bl_pkts[b] = 0;
                  block_touch(b);
                  v.reason = REASON_ESC;
                  v.bpkts = 0;
               end
            end
         end
         rate_touch(r);
         v.wpkts = rt_pkts[r];
         v.wbytes = rt_bytes[r];
      end
      return v;
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_verdicts.push_back(limiter_verdict(offered));
            void'(pending_items.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= 32)) begin
               offered = pending_items[0];
               req_valid <= 1;
               req_mode <= offered.mode;
               req_is_v6 <= offered.v6;
               req_addr_hi <= offered.hi;
               req_addr_lo <= offered.lo;
               req_pkt_len <= offered.len;
               req_timestamp_ns <= offered.ts;
               req_set_flag <= offered.flag;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            exp_v = expected_verdicts.pop_front();
            if (rsp_drop !== exp_v.drop || rsp_reason !== exp_v.reason ||
                rsp_hit_flag !== exp_v.hit_flag || rsp_window_packets !== exp_v.wpkts ||
                rsp_window_bytes !== exp_v.wbytes || rsp_blocked_packets !== exp_v.bpkts) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  exp drop %0d reason %0d flag %0d wp %0d wb %0d bp %0d",
                     exp_v.drop, exp_v.reason, exp_v.hit_flag, exp_v.wpkts,
                     exp_v.wbytes, exp_v.bpkts);
                  $display("  got drop %0d reason %0d flag %0d wp %0d wb %0d bp %0d",
                     rsp_drop, rsp_reason, rsp_hit_flag,
                     rsp_window_packets, rsp_window_bytes, rsp_blocked_packets);
               end
            end
         end
      end
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1;
      end else if (hold_request) begin
         hold_request = 0;
         hold_cnt <= LONG_HOLD;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 32);
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("source_rate_limiter_blocklist_core test failed");
         $finish;
      end
   end

   task automatic add_item(bit mode, bit v6, logic [63:0] hi, logic [63:0] lo,
                           logic [15:0] len, logic [63:0] ts, logic [2:0] flag);
      pkt_item_type it;
      it = '{mode, v6, hi, lo, len, ts, flag};
      pending_items.push_back(it);
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_verdicts.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [39:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_WINDOW_NS:   cfg_window = val;
         CSR_MAX_PACKETS: cfg_max_pkts = val[23:0];
         CSR_MAX_BYTES:   cfg_max_bytes = val[31:0];
         CSR_ESCALATE:    cfg_escalate = val[7:0];
         CSR_IPV6_ENABLE: cfg_v6_en = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_limits(logic [39:0] win, logic [23:0] mp, logic [31:0] mb,
                             logic [7:0] esc, bit v6en);
      write_reg(CSR_WINDOW_NS, win);
      write_reg(CSR_MAX_PACKETS, {16'd0, mp});
      write_reg(CSR_MAX_BYTES, {8'd0, mb});
      write_reg(CSR_ESCALATE, {32'd0, esc});
      write_reg(CSR_IPV6_ENABLE, {39'd0, v6en});
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // random traffic from an address pool, with some noise and host writes
   task automatic random_traffic(int n, int pool_n, int step_max);
      logic [63:0] hi, lo;
      bit          v6;
      for (int p = 0; p < pool_n; p++) begin
         pool_v6[p] = $urandom_range(0, 2) == 0;
         pool_hi[p] = pool_v6[p] ? {$urandom, $urandom} : 64'd0;
         pool_lo[p] = {$urandom, $urandom};
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 88) begin
            int p;
            p = $urandom_range(0, pool_n - 1);
            v6 = pool_v6[p];
            hi = pool_hi[p];
            lo = pool_lo[p];
            // ignored bits of an ipv4 key still toggle
            if (!v6) begin
               hi = {$urandom, $urandom};
               lo[63:32] = $urandom;
            end
         end else begin
            v6 = $urandom_range(0, 1);
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
         end
         if ($urandom_range(0, 99) < 4) now_ts = {$urandom, $urandom};
         else now_ts = now_ts + $urandom_range(0, step_max);
         add_item($urandom_range(0, 99) < 12, v6, hi, lo,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500)),
                  now_ts, 3'($urandom_range(0, 7)));
      end
   endtask

   initial begin
      cfg_window = WINDOW_NS_RST;
      cfg_max_pkts = MAX_PACKETS_RST;
      cfg_max_bytes = MAX_BYTES_RST;
      cfg_escalate = ESCALATE_RST;
      cfg_v6_en = 1;
      for (int j = 0; j < NE; j++) begin
         bl_valid[j] = 0;
         bl_age[j] = j;
         rt_valid[j] = 0;
         rt_age[j] = j;
      end
      now_ts = 64'd5_000_000_000;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed items under reset limits
      add_item(0, 0, '1, 64'hFFFF_FFFF_0A00_0001, 16'd0, 64'd0, 3'd0);
      add_item(0, 0, 64'd0, 64'h0000_0000_0A00_0001, 16'hFFFF, 64'd100, 3'd7);
      add_item(0, 1, '1, '1, 16'd64, 64'd200, 3'd0);
      add_item(1, 0, 64'd0, 64'h0A00_0001, 16'd0, 64'd3_000_000_000, 3'd1);
      add_item(0, 0, 64'd0, 64'h0A00_0001, 16'd40, 64'd3_100_000_000, 3'd0);
      add_item(1, 0, 64'd0, 64'h0A00_0001, 16'd0, 64'd3_200_000_000, 3'd0);
      add_item(0, 0, 64'd0, 64'h0A00_0001, 16'd40, 64'd3_300_000_000, 3'd0);
      add_item(1, 0, 64'd0, 64'h0A00_0099, 16'd0, 64'd3_400_000_000, 3'd0);
      add_item(1, 1, 64'd1, 64'd2, 16'd0, 64'd3_500_000_000, 3'd6);
      add_item(1, 1, 64'd1, 64'd2, 16'd0, 64'd3_500_000_000, 3'd7);
      add_item(1, 1, 64'd1, 64'd2, 16'd0, 64'd3_600_000_000, 3'd2);
      add_item(1, 1, 64'd1, 64'd3, 16'd0, 64'd3_700_000_000, 3'd3);
      add_item(1, 0, 64'd0, 64'h0B00_0001, 16'd0, 64'd3_800_000_000, 3'd4);
      add_item(1, 0, 64'd0, 64'h0B00_0002, 16'd0, '1, 3'd5);
      add_item(0, 1, 64'd1, 64'd2, 16'd100, '1, 3'd0);
      add_item(0, 0, 64'd0, 64'h0A00_0001, 16'd1, 64'd10, 3'd0);
      drain();

      // escalation path with tight limits
      set_limits(40'd1_000_000, 24'd1, 32'hFFFF_FFFF, 8'd1, 1'b1);
      add_item(1, 0, 64'd0, 64'h0C00_0001, 16'd0, 64'd20, 3'd3);
      add_item(1, 0, 64'd0, 64'h0C00_0001, 16'd0, 64'd21, 3'd0);
      for (int i = 0; i < 4; i++) add_item(0, 0, 64'd0, 64'h0C00_0001, 16'd10, 64'd30 + i, 3'd0);
      for (int i = 0; i < 3; i++) add_item(0, 1, 64'd7, 64'd8, 16'd10, 64'd40 + i, 3'd0);
      drain();

      // ipv6 checking off, extreme minimum limits
      set_limits(40'd1, 24'd1, 32'd1, 8'd255, 1'b0);
      add_item(0, 1, 64'd7, 64'd8, 16'd10, 64'd50, 3'd0);
      add_item(1, 1, 64'd9, 64'd9, 16'd0, 64'd51, 3'd5);
      add_item(0, 0, 64'd0, 64'h0D00_0001, 16'd0, 64'd52, 3'd0);
      add_item(0, 0, 64'd0, 64'h0D00_0001, 16'd0, 64'd52, 3'd0);
      random_traffic(60, 6, 2);
      drain();

      // tight window with a long receiver hold-off
      set_limits(40'd3000, 24'd2, 32'd3000, 8'd1, 1'b1);
      hold_request = 1;
      random_traffic(90, 6, 600);
      drain();

      // widest limits, many sources to force replacement
      set_limits(40'hFF_FFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b1);
      random_traffic(90, 80, 100000);
      drain();

      // no idling on either side
      quiet = 1;
      set_limits(40'd5000, 24'd3, 32'hFFFF_FFFF, 8'd2, 1'b1);
      random_traffic(80, 5, 400);
      drain();
      quiet = 0;

      set_limits(40'd100000, 24'd4, 32'd200000, 8'd3, 1'b1);
      random_traffic(80, 8, 5000);
      drain();

      done = 1;
      if (errors == 0 && expected_verdicts.size() == 0)
         $display("source_rate_limiter_blocklist_core test passed");
      else
         $display("source_rate_limiter_blocklist_core test failed");
      $finish;
   end

endmodule
